/* hdl/swmf_pkg.sv */
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared types and constants of the sliding window mean filter: register
// indexes, state encodings and the window control bundle.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int WLEN_W      = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIENTATION   = 2'd1;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_START,
    S_DIVIDE,
    S_EMIT,
    S_FLUSH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_SHIFT,
    DIV_SIGN
  } div_state_t;

  typedef struct packed {
    logic push;
    logic retire;
    logic clear;
  } swmf_win_ctrl_t;

endpackage

/* hdl/swmf_window.sv */
// ----------------------------------------------------------------------------
// swmf_window
// Sample ring, presence marks, running sum and counts of the window.
// ----------------------------------------------------------------------------
module swmf_window import swmf_pkg::*; #(
  parameter int MAX_WINDOW   = 32,
  parameter int SAMPLE_WIDTH = 32,
  parameter int CW           = $clog2(MAX_WINDOW + 1),
  parameter int SUM_W        = SAMPLE_WIDTH + CW
) (
  input  logic                           clk,
  input  logic                           rst,
  input  swmf_win_ctrl_t                 ctrl,
  input  logic [CW-1:0]                  n_eff,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           sample_valid,
  output logic signed [SUM_W-1:0]        running_sum,
  output logic [CW-1:0]                  valid_count,
  output logic [CW-1:0]                  fill_count
);

  localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [PW:0] RING_SIZE = (PW+1)'(MAX_WINDOW);
  localparam logic [PW-1:0] LAST_SLOT = PW'(MAX_WINDOW - 1);

  logic [SAMPLE_WIDTH-1:0] ring [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] rd_data;
  logic [MAX_WINDOW-1:0]   marks;
  logic [MAX_WINDOW-1:0]   marks_next;
  logic [PW-1:0]           wp;
  logic                    evict;

  logic                    full_before;
  logic [PW:0]             idx_sum;
  logic [PW-1:0]           old_idx;
  logic                    evict_now;

  always_comb begin
    full_before = (fill_count >= n_eff);
    idx_sum     = {1'b0, wp} + RING_SIZE - (PW+1)'(n_eff);
    old_idx     = (idx_sum >= RING_SIZE) ? PW'(idx_sum - RING_SIZE) : idx_sum[PW-1:0];
    evict_now   = full_before && marks[old_idx];
  end

  // Drop the outgoing mark, then set the mark of the incoming slot.
  always_comb begin
    marks_next = marks;
    if (full_before) begin
      marks_next[old_idx] = 1'b0;
    end
    marks_next[wp] = sample_valid;
  end

  // Read the outgoing sample before the new one lands in its slot, which may be the same one.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      rd_data     <= ring[old_idx];
      ring[wp]    <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      marks       <= '0;
      wp          <= '0;
      evict       <= 1'b0;
      valid_count <= '0;
      fill_count  <= '0;
    end else if (ctrl.push) begin
      if (!full_before) begin
        fill_count <= fill_count + CW'(1);
      end
      marks       <= marks_next;
      wp          <= (wp == LAST_SLOT) ? '0 : wp + PW'(1);
      evict       <= evict_now;
      valid_count <= valid_count + CW'(sample_valid) - CW'(evict_now);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      running_sum <= '0;
    end else if (ctrl.push && sample_valid) begin
      running_sum <= running_sum + {{CW{sample[SAMPLE_WIDTH-1]}}, sample};
    end else if (ctrl.retire && evict) begin
      running_sum <= running_sum - {{CW{rd_data[SAMPLE_WIDTH-1]}}, rd_data};
    end
  end

  a_count_matches_marks: assert property (@(posedge clk) disable iff (rst)
    $countones(marks) == int'(valid_count))
    else $error("valid count disagrees with presence marks");

  a_valid_within_fill: assert property (@(posedge clk) disable iff (rst)
    valid_count <= fill_count)
    else $error("more valid samples than filled slots");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(fill_count) <= MAX_WINDOW)
    else $error("fill count beyond ring size");

endmodule

/* hdl/swmf_divider.sv */
// ----------------------------------------------------------------------------
// swmf_divider
// Bit-serial signed divider: one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module swmf_divider import swmf_pkg::*; #(
  parameter int SUM_W = 38,
  parameter int CW    = 6,
  parameter int OUT_W = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CW-1:0]           divisor,
  output logic                    done,
  output logic [OUT_W-1:0]        quotient
);

  localparam int IW = $clog2(SUM_W + 1);

  div_state_t       state;
  div_state_t       state_next;
  logic [SUM_W-1:0] acc;
  logic [CW-1:0]    rem;
  logic [CW-1:0]    dvs;
  logic             neg;
  logic [IW-1:0]    cnt;
  logic [CW:0]      trial;
  logic [CW:0]      diff;
  logic             fits;

  always_comb begin
    trial = {rem, acc[SUM_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == DIV_SIGN);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE:  if (start) state_next = DIV_SHIFT;
      DIV_SHIFT: if (cnt == IW'(1)) state_next = DIV_SIGN;
      DIV_SIGN:  state_next = DIV_IDLE;
      default:   state_next = DIV_IDLE;
    endcase
  end

  // Dividend bits leave at the top of acc while quotient bits enter below.
  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        if (start) begin
          acc <= dividend[SUM_W-1] ? -dividend : dividend;
          neg <= dividend[SUM_W-1];
          rem <= '0;
          dvs <= divisor;
          cnt <= IW'(SUM_W);
        end
      end
      DIV_SHIFT: begin
        acc <= {acc[SUM_W-2:0], fits};
        rem <= fits ? diff[CW-1:0] : trial[CW-1:0];
        cnt <= cnt - IW'(1);
      end
      DIV_SIGN: begin
        quotient <= neg ? -acc[OUT_W-1:0] : acc[OUT_W-1:0];
      end
      default: ;
    endcase
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    state == DIV_SHIFT |-> rem < dvs)
    else $error("partial remainder not reduced");

  a_nonzero_divisor: assert property (@(posedge clk) disable iff (rst)
    state == DIV_SHIFT |-> dvs != '0)
    else $error("division by zero count");

  a_done_after_sign: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == DIV_SIGN))
    else $error("done without sign step");

endmodule

/* hdl/sliding_window_mean_filter_core.sv */
// ----------------------------------------------------------------------------
// sliding_window_mean_filter_core
// Moving mean over valid samples in a window of up to MAX_WINDOW entries.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with sample, sample_valid, series_end.
// Output channel: out_valid/out_stall with mean_value, mean_valid and
// last_result; a transaction moves on an edge with valid high, stall low.
// Configuration: cfg_we/cfg_index/cfg_data write window_length (index 0) or
// orientation (index 1); either write also clears the series state.
// When a mean is computed, an input transaction runs through the bit-serial
// divider, which produces one quotient bit per cycle over SUM_W =
// SAMPLE_WIDTH + clog2(MAX_WINDOW + 1) bits; items that yield no valid mean
// skip the divider. in_stall is high from acceptance until the last result of
// the item, if it has one, is in the output register. In leading mode a series
// end flushes one missing result for each result still owed.
// The output register holds a result while out_stall is high; the next item
// is accepted meanwhile, and the core waits only when it needs that register.
// Reset: window length 1, trailing mode, empty window, no result pending.
// ----------------------------------------------------------------------------
module sliding_window_mean_filter_core import swmf_pkg::*; #(
  parameter int MAX_WINDOW   = 32,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           sample_valid,
  input  logic                           series_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] mean_value,
  output logic                           mean_valid,
  output logic                           last_result
);

  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_WIDTH + CW;

  logic [WLEN_W-1:0]       window_length;
  logic                    orientation;
  logic [CW-1:0]           n_eff;

  ctrl_state_t             state;
  ctrl_state_t             state_next;
  logic                    end_flag;
  logic                    full_after_q;
  logic                    mean_ok;
  logic [CW-1:0]           flush_left;

  swmf_win_ctrl_t          win_ctrl;
  logic signed [SUM_W-1:0] running_sum;
  logic [CW-1:0]           valid_count;
  logic [CW-1:0]           fill_count;

  logic                    div_start;
  logic                    div_done;
  logic [SAMPLE_WIDTH-1:0] div_quotient;

  logic                    in_fire;
  logic                    cfg_hit;
  logic                    slot_free;
  logic                    has_mean;
  logic                    more_flush;
  logic                    out_load;
  logic                    out_last_next;
  logic                    out_mean_next;
  logic                    full_before;
  logic [CW-1:0]           fill_after;
  logic                    full_after;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign cfg_hit  = cfg_we && (cfg_index == REG_WINDOW_LENGTH || cfg_index == REG_ORIENTATION);

  always_comb begin
    if (window_length == '0) begin
      n_eff = CW'(1);
    end else if ((WLEN_W+1)'(window_length) > (WLEN_W+1)'(MAX_WINDOW)) begin
      n_eff = CW'(MAX_WINDOW);
    end else begin
      n_eff = CW'(window_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WLEN_RESET;
      orientation   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data;
        REG_ORIENTATION:   orientation   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Results still owed by a leading window if the series ends here.
  always_comb begin
    full_before = (fill_count >= n_eff);
    fill_after  = full_before ? fill_count : fill_count + CW'(1);
    full_after  = (fill_after >= n_eff);
  end

  swmf_window #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CW           (CW),
    .SUM_W        (SUM_W)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (win_ctrl),
    .n_eff        (n_eff),
    .sample       (sample),
    .sample_valid (sample_valid),
    .running_sum  (running_sum),
    .valid_count  (valid_count),
    .fill_count   (fill_count)
  );

  swmf_divider #(
    .SUM_W    (SUM_W),
    .CW       (CW),
    .OUT_W    (SAMPLE_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_sum),
    .divisor  (valid_count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign slot_free  = !out_valid || !out_stall;
  assign has_mean   = !orientation || full_after_q;
  assign more_flush = orientation && end_flag && (flush_left != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    win_ctrl      = '0;
    win_ctrl.clear = cfg_hit;
    div_start     = 1'b0;
    out_load      = 1'b0;
    out_last_next = 1'b0;
    out_mean_next = 1'b0;
    case (state)
      S_IDLE: begin
        win_ctrl.push = in_fire;
        if (in_fire) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        win_ctrl.retire = 1'b1;
        state_next      = S_START;
      end
      S_START: begin
        // The divider captures sum and count on this edge; drop the series after.
        div_start = full_after_q && (valid_count != '0);
        if (end_flag) win_ctrl.clear = 1'b1;
        state_next = div_start ? S_DIVIDE : S_EMIT;
      end
      S_DIVIDE: begin
        if (div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!has_mean) begin
          state_next = more_flush ? S_FLUSH : S_IDLE;
        end else if (slot_free) begin
          out_load      = 1'b1;
          out_mean_next = mean_ok;
          out_last_next = !more_flush;
          state_next    = more_flush ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_last_next = (flush_left == CW'(1));
          if (flush_left == CW'(1)) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      end_flag     <= series_end;
      full_after_q <= full_after;
      flush_left   <= full_after ? n_eff - CW'(1) : fill_after;
    end else if (state == S_FLUSH && out_load) begin
      flush_left   <= flush_left - CW'(1);
    end
    if (state == S_START) begin
      mean_ok <= full_after_q && (valid_count != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_value  <= out_mean_next ? div_quotient : '0;
      mean_valid  <= out_mean_next;
      last_result <= out_last_next;
    end
  end

  a_flush_has_work: assert property (@(posedge clk) disable iff (rst)
    state == S_FLUSH |-> flush_left != '0)
    else $error("flush state with nothing left to flush");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    out_load && out_last_next |=> state == S_IDLE)
    else $error("final result loaded but item still active");

  a_missing_reads_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mean_valid |-> mean_value == '0)
    else $error("missing result carries a nonzero value");

  a_done_while_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIVIDE)
    else $error("divider finished outside the wait state");

endmodule
